### rtl/sil_pkg.sv
// ----------------------------------------------------------------------------
// Sorted insertion list package
// Shared payload types, command and status codes, and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

  // Default number of entries held by the store
  localparam int SIL_DEPTH = 16;

  // Input command codes
  localparam logic [1:0] CMD_INSERT    = 2'd0;
  localparam logic [1:0] CMD_DUMP_ASC  = 2'd1;
  localparam logic [1:0] CMD_DUMP_DESC = 2'd2;
  localparam logic [1:0] CMD_CLEAR     = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_ELEMENT  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } sil_in_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               last;
    logic [2:0]         status;
  } sil_out_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    DP_NOP,
    DP_INSERT,
    DP_DROP,
    DP_EMPTY,
    DP_CLEAR,
    DP_DUMP_START,
    DP_ROT_ASC,
    DP_ROT_DESC
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } sil_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_busy;
    logic dump_done;
  } sil_stat_t;

endpackage

`default_nettype wire

### rtl/sil_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted insertion list controller
// Decodes accepted commands and sequences the rotation steps of a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_ctrl
  import sil_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire logic [1:0] command_i,
  input  wire sil_stat_t stat_i,
  output      sil_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   desc_q, desc_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE) | stat_i.out_busy;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d   = state_q;
    desc_d    = desc_q;
    cmd_o.op  = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_INSERT: begin
              cmd_o.op = stat_i.full ? DP_DROP : DP_INSERT;
            end
            CMD_DUMP_ASC, CMD_DUMP_DESC: begin
              if (stat_i.empty) begin
                cmd_o.op = DP_EMPTY;
              end else begin
                cmd_o.op = DP_DUMP_START;
                state_d  = S_DUMP;
                desc_d   = (command_i == CMD_DUMP_DESC);
              end
            end
            CMD_CLEAR: begin
              cmd_o.op = DP_CLEAR;
            end
            default: begin
              cmd_o.op = DP_NOP;
            end
          endcase
        end
      end
      S_DUMP: begin
        // advance the rotation only when the output register can take a result
        if (!stat_i.out_busy) begin
          cmd_o.op = desc_q ? DP_ROT_DESC : DP_ROT_ASC;
          if (stat_i.dump_done) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      desc_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      desc_q  <= desc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sil_datapath.sv
// ----------------------------------------------------------------------------
// Sorted insertion list datapath
// Row of compare-and-shift cells, entry count, dump step counter and the
// output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_datapath
  import sil_pkg::*;
#(
  parameter int Depth = SIL_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sil_cmd_t           cmd_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               out_stall_i,
  output      sil_stat_t          stat_o,
  output      logic               out_valid_o,
  output      sil_out_t           out_data_o
);

  localparam int CntW  = $clog2(Depth + 1);
  localparam int StepW = $clog2(Depth);
  localparam logic [StepW-1:0] LastStep = StepW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  logic signed [31:0] entry_q [Depth];
  logic signed [31:0] entry_d [Depth];
  logic signed [31:0] shift_src [Depth];
  logic [Depth-1:0]   gt;
  logic [Depth-1:0]   slot;
  logic [Depth-1:0]   take_new;

  logic [CntW-1:0]  count_q, count_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  sil_out_t         out_data_q, out_data_d;

  logic [StepW-1:0] desc_idx;
  logic             asc_emit, asc_last, desc_emit, desc_last;

  // Compare-and-shift cells: on insert a cell above the insertion point takes its left
  // neighbor, the insertion cell takes the new value, the rest hold; a dump step rotates the row.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign gt[i]   = (CntW'(i) < count_q) && (entry_q[i] > value_i);
    assign slot[i] = gt[i] || (CntW'(i) == count_q);
    if (i == 0) begin : g_first
      assign take_new[i]  = 1'b1;
      assign shift_src[i] = value_i;
    end else begin : g_rest
      assign take_new[i]  = ~gt[i-1];
      assign shift_src[i] = entry_q[i-1];
    end

    always_comb begin
      entry_d[i] = entry_q[i];
      case (cmd_i.op)
        DP_INSERT: begin
          if (slot[i]) begin
            entry_d[i] = take_new[i] ? value_i : shift_src[i];
          end
        end
        DP_ROT_ASC: begin
          entry_d[i] = entry_q[(i + 1) % Depth];
        end
        DP_ROT_DESC: begin
          entry_d[i] = entry_q[(i + Depth - 1) % Depth];
        end
        default: begin
          entry_d[i] = entry_q[i];
        end
      endcase
    end
  end

  // Which original entry sits at the emit end of the row on this step
  assign asc_emit  = CntW'(step_q) < count_q;
  assign asc_last  = CntW'(step_q) == (count_q - CntW'(1));
  assign desc_idx  = LastStep - step_q;
  assign desc_emit = CntW'(desc_idx) < count_q;
  assign desc_last = (desc_idx == '0);

  always_comb begin
    count_d     = count_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    case (cmd_i.op)
      DP_INSERT: begin
        count_d     = count_q + CntW'(1);
        out_valid_d = 1'b1;
        out_data_d  = '{element: '0, last: 1'b1, status: ST_INSERTED};
      end
      DP_DROP: begin
        out_valid_d = 1'b1;
        out_data_d  = '{element: '0, last: 1'b1, status: ST_FULL};
      end
      DP_EMPTY: begin
        out_valid_d = 1'b1;
        out_data_d  = '{element: '0, last: 1'b1, status: ST_EMPTY};
      end
      DP_CLEAR: begin
        count_d     = '0;
        out_valid_d = 1'b1;
        out_data_d  = '{element: '0, last: 1'b1, status: ST_CLEARED};
      end
      DP_DUMP_START: begin
        step_d = '0;
      end
      DP_ROT_ASC: begin
        step_d = step_q + StepW'(1);
        if (asc_emit) begin
          out_valid_d = 1'b1;
          out_data_d  = '{element: entry_q[0], last: asc_last, status: ST_ELEMENT};
        end
      end
      DP_ROT_DESC: begin
        step_d = step_q + StepW'(1);
        if (desc_emit) begin
          out_valid_d = 1'b1;
          out_data_d  = '{element: entry_q[Depth-1], last: desc_last, status: ST_ELEMENT};
        end
      end
      default: begin
        out_valid_d = out_valid_q & out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    for (int k = 0; k < Depth; k++) begin
      entry_q[k] <= entry_d[k];
    end
  end

  assign stat_o.full      = (count_q == FullCnt);
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.out_busy  = out_valid_q & out_stall_i;
  assign stat_o.dump_done = (step_q == LastStep);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### rtl/sorted_insertion_list_top.sv
// ----------------------------------------------------------------------------
// Sorted insertion list
// Holds up to Depth signed 32-bit values in ascending, stable order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries a command and a
//   value; output channel out_valid_o / out_stall_i / out_data_o carries the
//   results. A transfer happens on a clock edge with valid high, stall low.
//   Insert, clear and a dump of an empty store give one result, which
//   appears in the cycle after the transfer; with the output free, such items
//   are taken one per cycle.
//   A dump arms first; then the row of compare-and-shift cells rotates one
//   place a cycle through a full turn and restores itself, emitting the
//   held entries in order; the input stalls for that time. Each rotation
//   step waits while a result sits unclaimed.
//   A stalled result holds on the output register; no new result is made
//   until it is taken, and the input is stalled meanwhile.
//   Reset empties the store (entry count zero) and drops any pending result;
//   there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insertion_list_top
  import sil_pkg::*;
#(
  parameter int Depth = SIL_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output      logic    in_stall_o,
  input  wire sil_in_t in_data_i,
  output      logic    out_valid_o,
  input  wire logic    out_stall_i,
  output      sil_out_t out_data_o
);

  sil_cmd_t  cmd;
  sil_stat_t stat;

  sil_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (in_data_i.command),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sil_datapath #(
    .Depth (Depth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (in_data_i.value),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/sil_checker.sv
// ----------------------------------------------------------------------------
// Sorted insertion list checker
// Port-level properties of the sorted insertion list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_checker
  import sil_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire sil_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire sil_out_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // insert and clear answer in the next cycle with a single final result
  a_single_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.command == CMD_INSERT || in_data_i.command == CMD_CLEAR)
    |=> out_valid_o && out_data_o.last)
    else $error("insert or clear result missing");

  // non-element results are single, final and carry no element
  a_non_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_ELEMENT
    |-> out_data_o.last && out_data_o.element == 32'sd0)
    else $error("bad non-element result");

  // only dump elements may be non-final
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.status == ST_ELEMENT)
    else $error("non-final result is not a dump element");

endmodule

bind sorted_insertion_list_top sil_checker u_sil_checker (.*);

`default_nettype wire
